@@ rtl/qwt_pkg.sv @@
// ----------------------------------------------------------------------------
// qwt_pkg: shared types and constants of the quoted word tokenizer
// Item and result layouts, result and error codes, character constants and
// the command that the classifying front hands to the emitting back end.
// ----------------------------------------------------------------------------
package qwt_pkg;

  // Default depth of the held whitespace store.
  localparam int unsigned HoldDepthDef = 16;
  // Width of store indexes and counts in a command; covers depths up to 63.
  localparam int unsigned HoldCntW = 6;
  // Results that follow the flushed whitespace of one item, at most.
  localparam int unsigned TailMax = 3;
  // Entries of the command queue between front and back end.
  localparam int unsigned FifoDepth = 2;

  // Characters with a meaning of their own.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_FAIL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_QUOTE        = 3'd1,
    ERR_BSLASH       = 3'd2,
    ERR_ESCAPE       = 3'd3,
    ERR_TRAIL_BSLASH = 3'd4,
    ERR_OPEN_QUOTE   = 3'd5,
    ERR_NO_SEP       = 3'd6,
    ERR_OVERFLOW     = 3'd7
  } err_e;

  // One input item.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] in_byte;
    logic       end_of_line;
  } in_item_t;

  // One result item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    err_e       error_code;
    logic       last_of_run;
  } res_item_t;

  // A result that the front end has fully worked out.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
  } tail_t;

  // Work for the back end caused by one input item: an optional write into
  // the whitespace store, a flush of the first flush_cnt held bytes, then
  // tail_n ready-made results.
  typedef struct packed {
    logic                      wr_en;
    logic [HoldCntW-1:0]       wr_idx;
    logic [7:0]                wr_byte;
    logic [HoldCntW-1:0]       flush_cnt;
    logic [1:0]                tail_n;
    tail_t [TailMax-1:0]       tail;
  } cmd_t;

  // Space, TAB, LF, VT, FF and CR.
  function automatic logic is_white(logic [7:0] c);
    return (c == ChSpace) || (c inside {[8'h09:8'h0D]});
  endfunction

endpackage

@@ rtl/qwt_front.sv @@
// ----------------------------------------------------------------------------
// qwt_front: input classifier of the quoted word tokenizer
// Accepts one item per cycle while the queue has room, advances the scan mode and
// the held whitespace count, and turns the item into at most one back end command.
// ----------------------------------------------------------------------------
module qwt_front
  import qwt_pkg::*;
#(
  parameter int unsigned HoldDepth = HoldDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  localparam int unsigned CntW = $clog2(HoldDepth + 1);

  typedef enum logic [7:0] {
    MODE_START  = 8'b0000_0001,
    MODE_GAP    = 8'b0000_0010,
    MODE_LEAD   = 8'b0000_0100,
    MODE_WORD   = 8'b0000_1000,
    MODE_QUOTE  = 8'b0001_0000,
    MODE_ESC    = 8'b0010_0000,
    MODE_CLOSED = 8'b0100_0000,
    MODE_ERR    = 8'b1000_0000
  } mode_e;

  mode_e            mode_q, mode_d, mode_mid;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [7:0]       c;
  logic             accept;
  logic             do_content, do_fail;
  err_e             fail_code;
  logic             tb_valid, fin0_valid, fin1_valid;
  tail_t            tb, fin0, fin1;
  logic [1:0]       tail_n;
  cmd_t             cmd;

  assign c          = in_data_i.in_byte;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Classify the byte against the scan mode, then close the line if asked.
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    do_content = 1'b0;
    do_fail    = 1'b0;
    fail_code  = ERR_NONE;
    tb_valid   = 1'b0;
    tb         = '0;
    cmd        = '0;

    if (in_data_i.has_byte) begin
      case (mode_q)
        MODE_START: begin
          if (!is_white(c)) begin
            if (c == ChQuote) begin
              mode_d = MODE_QUOTE;
            end else begin
              do_content = 1'b1;
            end
          end
        end
        MODE_GAP: begin
          if (c == ChSpace) begin
            mode_d = MODE_GAP;
          end else if (c == ChQuote) begin
            mode_d = MODE_QUOTE;
          end else if (is_white(c)) begin
            mode_d = MODE_LEAD;
          end else begin
            do_content = 1'b1;
          end
        end
        MODE_LEAD, MODE_WORD: begin
          if (c == ChSpace) begin
            cnt_d    = '0;
            mode_d   = MODE_GAP;
            tb_valid = 1'b1;
            tb.kind  = KIND_END;
          end else if (is_white(c)) begin
            // Whitespace after word content is held until its fate is known.
            if (mode_q == MODE_WORD) begin
              if (cnt_q >= CntW'(HoldDepth)) begin
                do_fail   = 1'b1;
                fail_code = ERR_OVERFLOW;
              end else begin
                cmd.wr_en   = 1'b1;
                cmd.wr_idx  = HoldCntW'(cnt_q);
                cmd.wr_byte = c;
                cnt_d       = cnt_q + CntW'(1);
              end
            end
          end else begin
            do_content = 1'b1;
          end
        end
        MODE_QUOTE: begin
          if (c == ChQuote) begin
            mode_d   = MODE_CLOSED;
            tb_valid = 1'b1;
            tb.kind  = KIND_END;
          end else if (c == ChBslash) begin
            mode_d = MODE_ESC;
          end else begin
            tb_valid = 1'b1;
            tb.kind  = KIND_BYTE;
            tb.data  = c;
          end
        end
        MODE_ESC: begin
          if (c == ChBslash || c == ChQuote) begin
            mode_d   = MODE_QUOTE;
            tb_valid = 1'b1;
            tb.kind  = KIND_BYTE;
            tb.data  = c;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_ESCAPE;
          end
        end
        MODE_CLOSED: begin
          if (c == ChSpace) begin
            mode_d = MODE_GAP;
          end else begin
            do_fail   = 1'b1;
            fail_code = ERR_NO_SEP;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase

      // Content byte of an unquoted word: releases the held whitespace.
      if (do_content) begin
        if (c == ChQuote) begin
          do_fail   = 1'b1;
          fail_code = ERR_QUOTE;
        end else if (c == ChBslash) begin
          do_fail   = 1'b1;
          fail_code = ERR_BSLASH;
        end else begin
          cmd.flush_cnt = HoldCntW'(cnt_q);
          cnt_d         = '0;
          mode_d        = MODE_WORD;
          tb_valid      = 1'b1;
          tb.kind       = KIND_BYTE;
          tb.data       = c;
        end
      end

      if (do_fail) begin
        mode_d   = MODE_ERR;
        cnt_d    = '0;
        tb_valid = 1'b1;
        tb.kind  = KIND_FAIL;
        tb.data  = '0;
        tb.err   = fail_code;
      end
    end

    mode_mid   = mode_d;
    fin0_valid = 1'b0;
    fin1_valid = 1'b0;
    fin0       = '0;
    fin1       = '0;

    // End of line: close what is open and report the line, unless it already failed.
    if (in_data_i.end_of_line) begin
      case (mode_mid)
        MODE_START, MODE_GAP, MODE_CLOSED: begin
          fin0_valid = 1'b1;
          fin0.kind  = KIND_OK;
        end
        MODE_LEAD, MODE_WORD: begin
          fin0_valid = 1'b1;
          fin0.kind  = KIND_END;
          fin1_valid = 1'b1;
          fin1.kind  = KIND_OK;
        end
        MODE_QUOTE: begin
          fin0_valid = 1'b1;
          fin0.kind  = KIND_FAIL;
          fin0.err   = ERR_OPEN_QUOTE;
        end
        MODE_ESC: begin
          fin0_valid = 1'b1;
          fin0.kind  = KIND_FAIL;
          fin0.err   = ERR_TRAIL_BSLASH;
        end
        default: begin
          fin0_valid = 1'b0;
        end
      endcase
      mode_d = MODE_START;
      cnt_d  = '0;
    end

    // Pack the results of this item in order.
    tail_n = 2'd0;
    if (tb_valid) begin
      cmd.tail[tail_n] = tb;
      tail_n           = tail_n + 2'd1;
    end
    if (fin0_valid) begin
      cmd.tail[tail_n] = fin0;
      tail_n           = tail_n + 2'd1;
    end
    if (fin1_valid) begin
      cmd.tail[tail_n] = fin1;
      tail_n           = tail_n + 2'd1;
    end
    cmd.tail_n = tail_n;
  end

  // Only items that write the store or give results need the back end.
  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.wr_en || (cmd.tail_n != 2'd0));

  // Scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // Whitespace is only ever held inside an unquoted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_WORD) |-> (cnt_q == '0))
    else $error("held whitespace outside an unquoted word");

  // A flush never asks for more bytes than the store holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (cmd_o.flush_cnt <= HoldCntW'(HoldDepth)))
    else $error("flush longer than the whitespace store");

endmodule

@@ rtl/qwt_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// qwt_cmd_fifo: command queue of the quoted word tokenizer
// A short register queue that lets the classifier and the emitter stall
// independently of each other.
// ----------------------------------------------------------------------------
module qwt_cmd_fifo
  import qwt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  cmd_t            entry_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o       = (count_q == CntW'(FifoDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("command pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> head_valid_o)
    else $error("command popped from an empty queue");

endmodule

@@ rtl/qwt_back.sv @@
// ----------------------------------------------------------------------------
// qwt_back: result emitter of the quoted word tokenizer
// Owns the held whitespace store, carries out one command at a time and sends
// one result per cycle, when not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module qwt_back
  import qwt_pkg::*;
#(
  parameter int unsigned HoldDepth = HoldDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_item_t out_data_o
);

  localparam int unsigned IdxW = $clog2(HoldDepth);

  logic [7:0]          mem_q [HoldDepth];
  logic [7:0]          rdata_q;
  logic [IdxW-1:0]     rd_addr;

  cmd_t                cur_q, cur_d;
  logic                cur_valid_q, cur_valid_d;
  logic [HoldCntW-1:0] fidx_q, fidx_d;
  logic [1:0]          tidx_q, tidx_d;
  logic                out_valid_q, out_valid_d;
  res_item_t           out_q, out_d;

  logic                in_flush, adv, done;
  res_item_t           res;
  tail_t               t;

  // Current result: a held byte during the flush, then the prepared tail.
  always_comb begin
    in_flush = (fidx_q < cur_q.flush_cnt);
    t        = cur_q.tail[tidx_q];
    res      = '0;
    if (in_flush) begin
      res.kind     = KIND_BYTE;
      res.out_byte = rdata_q;
    end else begin
      res.kind        = t.kind;
      res.out_byte    = t.data;
      res.error_code  = t.err;
      res.last_of_run = (tidx_q == (cur_q.tail_n - 2'd1));
    end
  end

  assign adv   = cur_valid_q && (!out_valid_q || out_ready_i);
  assign done  = adv && !in_flush && res.last_of_run;
  assign pop_o = head_valid_i && (!cur_valid_q || done);

  // Command sequencing and the output stage.
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    fidx_d      = fidx_q;
    tidx_d      = tidx_q;
    if (adv) begin
      if (in_flush) begin
        fidx_d = fidx_q + HoldCntW'(1);
      end else begin
        tidx_d = tidx_q + 2'd1;
      end
    end
    if (done) begin
      cur_valid_d = 1'b0;
    end
    if (pop_o) begin
      cur_d       = head_i;
      cur_valid_d = (head_i.tail_n != 2'd0);
      fidx_d      = '0;
      tidx_d      = '0;
    end

    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // The read address follows the byte that will be sent next.
  always_comb begin
    if (fidx_d < HoldCntW'(HoldDepth)) begin
      rd_addr = fidx_d[IdxW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // Held whitespace store: written when a command is taken, read every cycle.
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.wr_en) begin
      mem_q[head_i.wr_idx[IdxW-1:0]] <= head_i.wr_byte;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      fidx_q      <= '0;
      tidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      fidx_q      <= fidx_d;
      tidx_q      <= tidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An error ends the line, so it is always the final result of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_FAIL) |-> out_data_o.last_of_run)
    else $error("error result not last of its item");

  // A new command is only taken once the previous one has been fully sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cur_valid_q) |-> done)
    else $error("command taken while another is in progress");

endmodule

@@ rtl/quoted_word_tokenizer.sv @@
// ----------------------------------------------------------------------------
// quoted_word_tokenizer: splits a byte stream into quoted or unquoted words
// Top level joining the classifier, the command queue and the emitter.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one byte, an end
//   of line mark, or both per transfer. Output channel (out_valid_o/
//   out_ready_i/out_data_o) carries word bytes, word ends and one final
//   success or error per line; last_of_run marks the final result of an item.
//   After an error the rest of the line is dropped and the receiver discards
//   the words of that line already sent.
// Timing
//   A result passes through the command queue, the emitter's command register
//   and the output register. The emitter sends one result per cycle while the
//   receiver is ready; an item has one result in most cases, up to HoldDepth + 3
//   when a content byte releases held whitespace. The emitter is the limit; the
//   classifier takes one item per cycle while the two-entry queue has room.
// Reset and stalls
//   Reset puts the scanner at the start of a line and empties the queue and
//   the output stage; the whitespace store needs no clearing. When the
//   receiver stalls, the output holds, the queue fills and in_ready_o falls.
// ----------------------------------------------------------------------------
module quoted_word_tokenizer
  import qwt_pkg::*;
#(
  parameter int unsigned HoldDepth = HoldDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output res_item_t out_data_o
);

  logic push, full, pop, head_valid;
  cmd_t cmd, head;

  // Classifier.
  qwt_front #(
    .HoldDepth(HoldDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  // Command queue.
  qwt_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (cmd),
    .full_o      (full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // Emitter.
  qwt_back #(
    .HoldDepth(HoldDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
